@@ design/cse_pkg.sv @@
// Shared types and constants for the CAN signal extract/insert core.
// Used by cse_ctrl, cse_datapath and can_signal_extract_insert_core.
`default_nettype none

package cse_pkg;

  // Payload store geometry.
  localparam int FRAME_BYTES = 64;
  localparam int FRAME_AW    = $clog2(FRAME_BYTES);
  localparam int ADDR_W      = 7;   // byte address of the signal walk, up to byte 71

  // A signal of up to 64 bits touches at most nine consecutive bytes.
  localparam int WIN_BYTES   = 9;
  localparam int WIN_W       = 8 * WIN_BYTES;
  localparam int CNT_W       = $clog2(WIN_BYTES + 1);

  localparam int MAX_SIZE    = 64;
  localparam int FLOAT_SIZE  = 32;
  localparam int DOUBLE_SIZE = 64;
  localparam int MIN_MSG     = 8;

  // Function codes.
  localparam logic [1:0] FUNC_WR_BYTE = 2'd0;
  localparam logic [1:0] FUNC_RD_BYTE = 2'd1;
  localparam logic [1:0] FUNC_DECODE  = 2'd2;
  localparam logic [1:0] FUNC_ENCODE  = 2'd3;

  // Value kinds.
  localparam logic [1:0] KIND_INT    = 2'd0;
  localparam logic [1:0] KIND_FLOAT  = 2'd1;
  localparam logic [1:0] KIND_DOUBLE = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_START     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_SIZE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IS_SIGNED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_KIND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_BYTES = 3'd5;

  typedef struct packed {
    logic [8:0] sig_start;
    logic [6:0] sig_size;
    logic       big_endian;
    logic       is_signed;
    logic [1:0] value_kind;
    logic [6:0] message_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  byte_index;
    logic [7:0]  byte_value;
    logic [63:0] raw_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [63:0] raw_out;
    logic        exceeds_frame;
    logic        bad_size;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;      // latch the accepted word
    logic             byte_acc;  // single byte write or read
    logic             sig_rd;    // read byte rd_num of the signal window
    logic             sig_cap;   // capture or rewrite byte cap_num of the window
    logic             fin;       // form the result
    logic [CNT_W-1:0] rd_num;
    logic [CNT_W-1:0] cap_num;
  } ctl_cmd_t;

endpackage

`default_nettype wire

@@ design/can_signal_extract_insert_core.sv @@
// CAN signal extract/insert core: byte access, DBC signal decode and encode.
// Byte write or read: the word passes the byte access and finish states before the result strobe.
// Decode or encode: the single payload port walks nine bytes one per cycle, then the
// finish state forms the result before the strobe.
// A new word is taken in the cycle the result is strobed; results cannot be stalled.
// Synchronous reset makes every payload byte read as zero and restores register defaults.
`default_nettype none

module can_signal_extract_insert_core
  import cse_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             item,
  output logic                      done,
  output out_item_t                 result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  ctl_cmd_t cmd;

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sig_start     <= 9'd0;
      cfg.sig_size      <= 7'd8;
      cfg.big_endian    <= 1'b0;
      cfg.is_signed     <= 1'b0;
      cfg.value_kind    <= KIND_INT;
      cfg.message_bytes <= 7'(MIN_MSG);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIG_START:     cfg.sig_start     <= cfg_data;
        REG_SIG_SIZE:      cfg.sig_size      <= cfg_data[6:0];
        REG_BIG_ENDIAN:    cfg.big_endian    <= cfg_data[0];
        REG_IS_SIGNED:     cfg.is_signed     <= cfg_data[0];
        REG_VALUE_KIND:    cfg.value_kind    <= cfg_data[1:0];
        REG_MESSAGE_BYTES: cfg.message_bytes <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  cse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item_func (item.func),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd)
  );

  cse_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .cmd    (cmd),
    .result (result)
  );

endmodule

`default_nettype wire

@@ design/cse_ctrl.sv @@
// Sequencing state machine of the CAN signal extract/insert core.
// Depends on cse_pkg; drives cse_datapath through a ctl_cmd_t command word.
`default_nettype none

module cse_ctrl
  import cse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] item_func,
  output logic            busy,
  output logic            done,
  output ctl_cmd_t        cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BYTE = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd         = '0;
    cmd.rd_num  = cnt;
    cmd.cap_num = cnt - CNT_W'(1);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          if ((item_func == FUNC_DECODE) || (item_func == FUNC_ENCODE)) begin
            state_next = S_RUN;
          end else begin
            state_next = S_BYTE;
          end
        end
      end
      S_BYTE: begin
        cmd.byte_acc = 1'b1;
        state_next   = S_FIN;
      end
      S_RUN: begin
        // Reads run one byte ahead of the capture or rewrite of the same byte.
        cmd.sig_rd  = (cnt < CNT_W'(WIN_BYTES));
        cmd.sig_cap = (cnt != '0);
        cnt_next    = cnt + CNT_W'(1);
        if (cnt == CNT_W'(WIN_BYTES)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= (state == S_FIN);
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

@@ design/cse_datapath.sv @@
// Payload store, signal windows and result register of the extract/insert core.
// Depends on cse_pkg; commanded by cse_ctrl.
`default_nettype none

module cse_datapath
  import cse_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire in_item_t  item,
  input  wire ctl_cmd_t  cmd,
  output out_item_t      result
);

  logic [7:0]          mem [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] valid;
  logic [7:0]          mem_q;
  logic                rd_ok;

  logic [1:0]          func_q;
  logic [5:0]          idx_q;
  logic [7:0]          bval_q;
  logic [WIN_W-1:0]    enc_mask;
  logic [WIN_W-1:0]    enc_data;
  logic [WIN_W-1:0]    dec_win;

  // Layout derived from the configuration, which the user must hold still during a word; the block does not enforce it.
  logic [6:0]  n;
  logic [2:0]  s;
  logic [5:0]  b0;
  logic [6:0]  sh;
  logic [63:0] mask;
  logic [6:0]  mb_eff;
  logic [9:0]  limit;
  logic [7:0]  fsize_m1;
  logic        ex_flag;
  logic        bad_flag;
  logic        ext_sign;

  always_comb begin
    if (cfg.sig_size == 7'd0) begin
      n = 7'd1;
    end else if (cfg.sig_size > 7'(MAX_SIZE)) begin
      n = 7'(MAX_SIZE);
    end else begin
      n = cfg.sig_size;
    end
    s  = cfg.sig_start[2:0];
    b0 = cfg.sig_start[8:3];
    // Motorola bytes sit in the window most significant first, so the signal
    // ends 65 + s - n bits above the window's bottom.
    sh = cfg.big_endian ? 7'(7'd65 + {4'd0, s} - n) : {4'd0, s};
    mask = ~64'd0 >> (7'(MAX_SIZE) - n);
    mb_eff = (cfg.message_bytes < 7'(MIN_MSG)) ? 7'(MIN_MSG) : cfg.message_bytes;
    limit = {mb_eff, 3'b000};
    fsize_m1 = 8'(n) + 8'd7 - 8'(s) - 8'd1;
    if (cfg.big_endian) begin
      ex_flag = (10'({b0, 3'b000}) + 10'({fsize_m1[7:3], 3'b000})) >= limit;
    end else begin
      ex_flag = (10'(cfg.sig_start) + 10'(n)) > limit;
    end
    if (cfg.value_kind == KIND_FLOAT) begin
      bad_flag = (cfg.sig_size != 7'(FLOAT_SIZE));
    end else if (cfg.value_kind == KIND_DOUBLE) begin
      bad_flag = (cfg.sig_size != 7'(DOUBLE_SIZE));
    end else begin
      bad_flag = 1'b0;
    end
    ext_sign = cfg.is_signed && (cfg.value_kind != KIND_FLOAT)
               && (cfg.value_kind != KIND_DOUBLE);
  end

  // Memory port control.
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              mem_rd;
  logic              wr_req;
  logic              rd_in;
  logic              wr_in;
  logic [7:0]        rd_byte;
  logic [7:0]        wdata;
  logic [3:0]        pos;
  logic [7:0]        m_b;
  logic [7:0]        d_b;

  always_comb begin
    pos     = cfg.big_endian ? 4'(4'(WIN_BYTES - 1) - 4'(cmd.cap_num)) : 4'(cmd.cap_num);
    rd_byte = rd_ok ? mem_q : 8'd0;
    m_b     = enc_mask[{pos, 3'b000} +: 8];
    d_b     = enc_data[{pos, 3'b000} +: 8];

    if (cmd.byte_acc) begin
      rd_addr = ADDR_W'(idx_q);
      wr_addr = ADDR_W'(idx_q);
      wdata   = bval_q;
    end else begin
      rd_addr = ADDR_W'(b0) + ADDR_W'(cmd.rd_num);
      wr_addr = ADDR_W'(b0) + ADDR_W'(cmd.cap_num);
      wdata   = (rd_byte & ~m_b) | (d_b & m_b);
    end
    mem_rd = (cmd.byte_acc && (func_q == FUNC_RD_BYTE)) || cmd.sig_rd;
    wr_req = (cmd.byte_acc && (func_q == FUNC_WR_BYTE))
             || (cmd.sig_cap && (func_q == FUNC_ENCODE));
    rd_in  = (rd_addr < ADDR_W'(FRAME_BYTES));
    wr_in  = (wr_addr < ADDR_W'(FRAME_BYTES));
  end

  always_ff @(posedge clk) begin
    if (wr_req && wr_in) begin
      mem[wr_addr[FRAME_AW-1:0]] <= wdata;
    end
    if (mem_rd) begin
      mem_q <= mem[rd_addr[FRAME_AW-1:0]];
    end
  end

  // A byte never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_req && wr_in) begin
        valid[wr_addr[FRAME_AW-1:0]] <= 1'b1;
      end
      if (mem_rd) begin
        rd_ok <= rd_in && valid[rd_addr[FRAME_AW-1:0]];
      end
    end
  end

  // Word latch and signal windows.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= item.func;
      idx_q    <= item.byte_index;
      bval_q   <= item.byte_value;
      enc_mask <= {8'd0, mask} << sh;
      enc_data <= {8'd0, item.raw_value & mask} << sh;
    end
    if (cmd.sig_cap && (func_q == FUNC_DECODE)) begin
      dec_win[{pos, 3'b000} +: 8] <= rd_byte;
    end
  end

  // Result forming.
  logic [63:0] raw_m;
  logic [63:0] raw_x;
  logic [5:0]  nm1;
  out_item_t   result_next;

  always_comb begin
    nm1   = 6'(n - 7'd1);
    raw_m = 64'(dec_win >> sh) & mask;
    raw_x = (ext_sign && raw_m[nm1]) ? (raw_m | ~mask) : raw_m;
  end

  always_comb begin
    result_next = '0;
    case (func_q)
      FUNC_RD_BYTE: begin
        result_next.byte_out = rd_byte;
      end
      FUNC_DECODE: begin
        result_next.raw_out       = raw_x;
        result_next.exceeds_frame = ex_flag;
        result_next.bad_size      = bad_flag;
      end
      FUNC_ENCODE: begin
        result_next.exceeds_frame = ex_flag;
        result_next.bad_size      = bad_flag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
